@@ rtl/core/fvrs_pkg.sv @@
// fvrs_pkg: shared types, constants and state encoding for the filtered value ring sampler.
// No dependencies; every rtl/core file refers to it by scoped names.
package fvrs_pkg;

	// Field widths
	localparam int VALUE_IN_W = 64;
	localparam int VALUE_W    = 32;
	localparam int TICK_W     = 32;
	localparam int SOURCE_W   = 10;
	localparam int RAND_W     = 16;
	localparam int PTRLIM_W   = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Stream packing
	localparam int S_TDATA_W  = 192;
	localparam int M_TDATA_W  = VALUE_W;
	localparam int M_TUSER_W  = 2;

	// Parameter defaults
	localparam int RING_DEPTH_DEF  = 16;
	localparam int PROBE_COUNT_DEF = 4;
	localparam int MAX_PROBES      = 4;
	localparam int PROBE_IDX_W     = 2;

	// Divider: bits retired per cycle
	localparam int DIV_STEP_BITS = 4;

	// Register reset values
	localparam logic [TICK_W-1:0]   RECENCY_RESET = 32'd64;
	localparam logic [RAND_W-1:0]   DIVISOR_RESET = 16'd12;
	localparam logic [PTRLIM_W-1:0] PTRLIM_RESET  = 31'h4000_0000;

	// Filter bounds
	localparam logic signed [VALUE_IN_W-1:0] LOW_BOUND  = -64'sd32;
	localparam logic signed [VALUE_IN_W-1:0] FD_FLOOR   = 64'sd2;
	localparam logic signed [VALUE_IN_W-1:0] INT32_TOP  = 64'sd2147483647;
	localparam logic signed [VALUE_IN_W-1:0] MINUS_ONE  = -64'sd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RECENCY = 2'd0,
		CFG_DIVISOR = 2'd1,
		CFG_PTRLIM  = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH_RD,
		ST_PUSH_CMP,
		ST_ROLL,
		ST_ROLL_WAIT,
		ST_PROBE,
		ST_PROBE_WAIT,
		ST_PROBE_CHK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [TICK_W-1:0]   tick;
		logic [SOURCE_W-1:0] source;
		logic                narrow;
	} slot_t;

	typedef struct packed {
		logic              start;
		logic [RAND_W-1:0] dividend;
		logic [RAND_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [RAND_W-1:0] rem;
	} div_rsp_t;

endpackage

@@ rtl/core/filtered_value_ring_sampler_unit.sv @@
// Filtered value ring sampler: push filter with dedup into a slot ring, random probing get.
// A push runs PUSH_RD, PUSH_CMP, OUT. A get runs ROLL, ROLL_WAIT, then OUT if the roll or an
// empty ring ends it, else PROBE, PROBE_WAIT, PROBE_CHK per slot probe, up to PROBE_COUNT probes.
// A new request is taken once the result is in the output register; OUT waits while it is held.
// The waits come from the shared remainder unit (16-bit remainder) and the slot memory read.
// Reset (arst_n low): ring empty, head 0, registers at defaults; slot memory itself not cleared.
module filtered_value_ring_sampler_unit #(
	parameter int RING_DEPTH  = fvrs_pkg::RING_DEPTH_DEF,
	parameter int PROBE_COUNT = fvrs_pkg::PROBE_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [63:0] value_in, [73:64] source_number, [74] narrow_mode, [75] typed_return,
	// [76] fd_registered, [108:77] tick_now, [124:109] inject_random,
	// [140:125] probe_random_a, [156:141] probe_random_b, [172:157] probe_random_c,
	// [188:173] probe_random_d, [191:189] zero
	input  logic [fvrs_pkg::S_TDATA_W-1:0]       s_tdata,
	// [0] op
	input  logic [0:0]                           s_tuser,
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [31:0] value_out
	output logic signed [fvrs_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] captured, [1] found
	output logic [fvrs_pkg::M_TUSER_W-1:0]       m_tuser,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fvrs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fvrs_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW  = $clog2(RING_DEPTH);
	localparam int CNW = $clog2(RING_DEPTH + 1);
	localparam int VW  = fvrs_pkg::VALUE_W;
	localparam int TW  = fvrs_pkg::TICK_W;
	localparam int SW  = fvrs_pkg::SOURCE_W;
	localparam int RW  = fvrs_pkg::RAND_W;
	localparam int PIW = fvrs_pkg::PROBE_IDX_W;

	// request field offsets within s_tdata
	localparam int OFS_SRC  = fvrs_pkg::VALUE_IN_W;
	localparam int OFS_NAR  = OFS_SRC + SW;
	localparam int OFS_TYP  = OFS_NAR + 1;
	localparam int OFS_FD   = OFS_TYP + 1;
	localparam int OFS_TICK = OFS_FD + 1;
	localparam int OFS_INJ  = OFS_TICK + TW;
	localparam int OFS_PRB  = OFS_INJ + RW;

	// ---------------------------------------------------------------
	// Configuration registers: written by the user only while idle, which the block does not enforce; always ready
	// ---------------------------------------------------------------
	logic [TW-1:0]                    recency_q;
	logic [RW-1:0]                    divisor_q;
	logic [fvrs_pkg::PTRLIM_W-1:0]    ptrlim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recency_q <= fvrs_pkg::RECENCY_RESET;
			divisor_q <= fvrs_pkg::DIVISOR_RESET;
			ptrlim_q  <= fvrs_pkg::PTRLIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fvrs_pkg::CFG_RECENCY: recency_q <= cfg_data[TW-1:0];
				fvrs_pkg::CFG_DIVISOR: divisor_q <= cfg_data[RW-1:0];
				fvrs_pkg::CFG_PTRLIM:  ptrlim_q  <= cfg_data[fvrs_pkg::PTRLIM_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Request capture
	// ---------------------------------------------------------------
	logic signed [fvrs_pkg::VALUE_IN_W-1:0] value_q;
	logic [SW-1:0]                          src_q;
	logic                                   narrow_q;
	logic                                   typed_q;
	logic                                   fdreg_q;
	logic [TW-1:0]                          tick_q;
	logic [RW-1:0]                          inj_q;
	logic [RW-1:0]                          probe_q [fvrs_pkg::MAX_PROBES];

	logic s_acc;
	assign s_acc = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (s_acc) begin
			value_q  <= s_tdata[fvrs_pkg::VALUE_IN_W-1:0];
			src_q    <= s_tdata[OFS_SRC +: SW];
			narrow_q <= s_tdata[OFS_NAR];
			typed_q  <= s_tdata[OFS_TYP];
			fdreg_q  <= s_tdata[OFS_FD];
			tick_q   <= s_tdata[OFS_TICK +: TW];
			inj_q    <= s_tdata[OFS_INJ +: RW];
			for (int p = 0; p < fvrs_pkg::MAX_PROBES; p++) begin
				probe_q[p] <= s_tdata[OFS_PRB + p*RW +: RW];
			end
		end
	end

	// ---------------------------------------------------------------
	// Ring pointers. Slots are written strictly in order and never
	// invalidated, so slot i is valid exactly when i < populated.
	// ---------------------------------------------------------------
	logic [AW-1:0]  head_q;
	logic           full_q;
	logic [CNW-1:0] populated;
	logic [AW-1:0]  prev_idx;

	assign populated = full_q ? CNW'(RING_DEPTH) : CNW'(head_q);
	assign prev_idx  = (head_q == '0) ? AW'(RING_DEPTH - 1) : head_q - 1'b1;

	// ---------------------------------------------------------------
	// Push filter, from the captured request
	// ---------------------------------------------------------------
	logic filt_ok;
	logic [VW-1:0] w32;

	assign w32 = value_q[VW-1:0];

	always_comb begin
		filt_ok = 1'b1;
		if (typed_q) filt_ok = 1'b0;
		if (value_q == fvrs_pkg::MINUS_ONE) filt_ok = 1'b0;
		if (value_q < fvrs_pkg::LOW_BOUND) filt_ok = 1'b0;
		if (value_q > fvrs_pkg::INT32_TOP) filt_ok = 1'b0;
		// positive above the pointer limit
		if (value_q > $signed({33'b0, ptrlim_q})) filt_ok = 1'b0;
		// registered descriptor
		if (fdreg_q && (value_q > fvrs_pkg::FD_FLOOR)) filt_ok = 1'b0;
	end

	// ---------------------------------------------------------------
	// Slot memory and remainder unit
	// ---------------------------------------------------------------
	logic               mem_we;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	fvrs_pkg::slot_t    mem_wdata;
	fvrs_pkg::slot_t    mem_rdata;
	fvrs_pkg::div_req_t div_req;
	fvrs_pkg::div_rsp_t div_rsp;

	assign mem_wdata.value  = w32;
	assign mem_wdata.tick   = tick_q;
	assign mem_wdata.source = src_q;
	assign mem_wdata.narrow = narrow_q;

	fvrs_slot_mem #(
		.DEPTH (RING_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (head_q),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fvrs_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------------------------------------------------------
	// Sequencer. One request at a time; the memory write of a push
	// lands before the next request is taken, so reads never overlap
	// a pending write to the same slot.
	// ---------------------------------------------------------------
	fvrs_pkg::state_t st_q, st_nxt;
	logic [PIW-1:0]   k_q;
	logic             k_clr, k_inc;
	logic             res_ld;
	logic             res_cap, res_found;
	logic [VW-1:0]    res_val;
	logic             cap_q, found_q;
	logic [VW-1:0]    val_q;
	logic             push_commit;
	logic             dup;
	logic [TW-1:0]    age;
	logic             out_free;

	assign out_free = !m_tvalid || m_tready;
	assign dup = (populated != '0) && (mem_rdata.value == w32) &&
		(mem_rdata.source == src_q) && (mem_rdata.narrow == narrow_q);
	assign age = tick_q - mem_rdata.tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fvrs_pkg::ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	always_comb begin
		st_nxt           = st_q;
		s_tready         = 1'b0;
		mem_we           = 1'b0;
		mem_re           = 1'b0;
		mem_raddr        = prev_idx;
		div_req.start    = 1'b0;
		div_req.dividend = probe_q[k_q];
		div_req.divisor  = RW'(populated);
		k_clr            = 1'b0;
		k_inc            = 1'b0;
		res_ld           = 1'b0;
		res_cap          = 1'b0;
		res_found        = 1'b0;
		res_val          = '0;
		push_commit      = 1'b0;
		case (st_q)
			fvrs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					st_nxt = s_tuser[0] ? fvrs_pkg::ST_ROLL : fvrs_pkg::ST_PUSH_RD;
				end
			end
			fvrs_pkg::ST_PUSH_RD: begin
				mem_re = 1'b1;
				st_nxt = fvrs_pkg::ST_PUSH_CMP;
			end
			fvrs_pkg::ST_PUSH_CMP: begin
				push_commit = filt_ok && !dup;
				mem_we      = push_commit;
				res_ld      = 1'b1;
				res_cap     = push_commit;
				st_nxt      = fvrs_pkg::ST_OUT;
			end
			fvrs_pkg::ST_ROLL: begin
				div_req.start    = 1'b1;
				div_req.dividend = inj_q;
				div_req.divisor  = (divisor_q == '0) ? RW'(1) : divisor_q;
				k_clr            = 1'b1;
				st_nxt           = fvrs_pkg::ST_ROLL_WAIT;
			end
			fvrs_pkg::ST_ROLL_WAIT: begin
				if (div_rsp.done) begin
					if ((div_rsp.rem != '0) || (populated == '0)) begin
						res_ld = 1'b1;
						st_nxt = fvrs_pkg::ST_OUT;
					end else begin
						st_nxt = fvrs_pkg::ST_PROBE;
					end
				end
			end
			fvrs_pkg::ST_PROBE: begin
				div_req.start = 1'b1;
				st_nxt        = fvrs_pkg::ST_PROBE_WAIT;
			end
			fvrs_pkg::ST_PROBE_WAIT: begin
				mem_raddr = div_rsp.rem[AW-1:0];
				if (div_rsp.done) begin
					mem_re = 1'b1;
					st_nxt = fvrs_pkg::ST_PROBE_CHK;
				end
			end
			fvrs_pkg::ST_PROBE_CHK: begin
				if (age <= recency_q) begin
					res_ld    = 1'b1;
					res_found = 1'b1;
					res_val   = mem_rdata.value;
					st_nxt    = fvrs_pkg::ST_OUT;
				end else if (k_q == PIW'(PROBE_COUNT - 1)) begin
					res_ld = 1'b1;
					st_nxt = fvrs_pkg::ST_OUT;
				end else begin
					k_inc  = 1'b1;
					st_nxt = fvrs_pkg::ST_PROBE;
				end
			end
			fvrs_pkg::ST_OUT: begin
				if (out_free) begin
					st_nxt = fvrs_pkg::ST_IDLE;
				end
			end
			default: begin
				st_nxt = fvrs_pkg::ST_IDLE;
			end
		endcase
	end

	// probe counter and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			head_q <= '0;
			full_q <= 1'b0;
		end else begin
			if (k_clr) begin
				k_q <= '0;
			end else if (k_inc) begin
				k_q <= k_q + 1'b1;
			end
			if (push_commit) begin
				if (head_q == AW'(RING_DEPTH - 1)) begin
					head_q <= '0;
					full_q <= 1'b1;
				end else begin
					head_q <= head_q + 1'b1;
				end
			end
		end
	end

	// result held until the output register frees up
	always_ff @(posedge clk) begin
		if (res_ld) begin
			cap_q   <= res_cap;
			found_q <= res_found;
			val_q   <= res_val;
		end
	end

	// ---------------------------------------------------------------
	// Output register: lets the next request in while this one waits
	// ---------------------------------------------------------------
	logic             m_valid_q;
	logic             m_cap_q, m_found_q;
	logic [VW-1:0]    m_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((st_q == fvrs_pkg::ST_OUT) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == fvrs_pkg::ST_OUT) && out_free) begin
			m_cap_q   <= cap_q;
			m_found_q <= found_q;
			m_val_q   <= val_q;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = $signed(m_val_q);
	assign m_tuser[0] = m_cap_q;
	assign m_tuser[1] = m_found_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_cap_found_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("captured and found both set");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata == '0)
		else $error("value nonzero without found");

	a_head_moves_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(head_q) |-> $past(push_commit))
		else $error("head moved without a capture");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(full_q))
		else $error("ring full flag dropped");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == fvrs_pkg::ST_PROBE_WAIT) && div_rsp.done |->
			div_rsp.rem < RW'(populated))
		else $error("probe index beyond populated slots");

endmodule

@@ rtl/core/fvrs_slot_mem.sv @@
// fvrs_slot_mem: slot storage, one write port and one read port, registered read data.
// Depends on fvrs_pkg (slot_t).
module fvrs_slot_mem #(
	parameter int DEPTH = fvrs_pkg::RING_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  fvrs_pkg::slot_t      wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output fvrs_pkg::slot_t      rdata
);

	fvrs_pkg::slot_t mem [DEPTH];
	fvrs_pkg::slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/fvrs_mod_unit.sv @@
// fvrs_mod_unit: iterative restoring remainder, DIV_STEP_BITS dividend bits per cycle.
// Depends on fvrs_pkg (div_req_t, div_rsp_t). Divisor must be nonzero.
module fvrs_mod_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  fvrs_pkg::div_req_t req,
	output fvrs_pkg::div_rsp_t rsp
);

	localparam int W     = fvrs_pkg::RAND_W;
	localparam int SB    = fvrs_pkg::DIV_STEP_BITS;
	localparam int STEPS = W / SB;
	localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W-1:0]  rem_nxt;
	logic [W-1:0]  dvd_nxt;
	logic [W:0]    trial;

	always_comb begin
		rem_nxt = rem_q;
		dvd_nxt = dvd_q;
		trial   = '0;
		for (int j = 0; j < SB; j++) begin
			trial   = {rem_nxt, dvd_nxt[W-1]};
			dvd_nxt = {dvd_nxt[W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
			end
			rem_nxt = trial[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= dvd_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

	// remainder is always reduced below the divisor
	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (div_q != '0) |-> rem_q < div_q)
		else $error("remainder not below divisor");

endmodule
